// ===== hw/rtl/dset_pkg.sv =====
// Shared types and constants of the dilated Sobel edge threshold unit.
package dset_pkg;

	// Configuration port.
	localparam int CFG_DW = 13;
	localparam int CFG_IW = 2;

	typedef enum logic [CFG_IW-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_WIDTH     = 2'd1,
		CFG_HEIGHT    = 2'd2
	} cfg_reg_t;

	// Field widths of the configuration registers and their reset values.
	localparam int THR_W = 12;
	localparam int FW_W  = 11;
	localparam int FH_W  = 13;

	localparam int THRESHOLD_RESET = 100;
	localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd480;

	// Arithmetic widths: gradients stay within +/-1020, a square within 20 bits.
	localparam int GRAD_W   = 11;
	localparam int SQ_W     = 20;
	localparam int THR_SQ_W = 2 * THR_W;

	localparam logic [THR_SQ_W-1:0] THR_SQ_RESET =
		THR_SQ_W'(THRESHOLD_RESET * THRESHOLD_RESET);

	// Result codes.
	localparam logic [7:0] EDGE_ON  = 8'd255;
	localparam logic [7:0] EDGE_OFF = 8'd0;

	// Queue between the front and the back part.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Output coordinate widths.
	localparam int ROW_W = 12;
	localparam int COL_W = 10;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} pix_t;

	typedef struct packed {
		logic [7:0]       edge_res;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             frame_done;
	} res_t;

	typedef logic signed [GRAD_W-1:0] grad_t;

	// One window that yields a result, as handed from the front to the back.
	typedef struct packed {
		grad_t            gx;
		grad_t            gy;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             done;
	} grad_item_t;

endpackage

// ===== hw/rtl/dset_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module dset_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Reads return the contents from before a write at the same edge.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

// ===== hw/rtl/dset_front.sv =====
// Front part: pixel intake, position tracking, line stores, window and gradients.
module dset_front import dset_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pix_t              pix,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  logic [FW_W-1:0]   frame_width,
	input  logic [FH_W-1:0]   frame_height,
	input  logic [QCNT_W-1:0] q_count,
	output logic              push,
	output grad_item_t        push_item
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int WCW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
	localparam int HCW = ($clog2(MAX_HEIGHT + 1) > FH_W) ? $clog2(MAX_HEIGHT + 1) : FH_W;
	localparam int DEPTH = 6 * MAX_WIDTH;
	localparam int AW  = $clog2(DEPTH);

	// Position of the next pixel and the line store slot of its row.
	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic [2:0]    slot_q;

	logic          accept;
	logic [XW-1:0] x;
	logic [YW-1:0] y;
	logic [2:0]    slot;
	logic [2:0]    slot_mid;
	logic [WCW-1:0] w_use;
	logic [HCW-1:0] h_use;
	logic [WCW-1:0] x_inc;
	logic [HCW-1:0] y_inc;
	logic           emit;
	logic           last;
	logic [XW-1:0]  x_m6;
	logic [YW-1:0]  y_m6;
	logic [XW-1:0]  col_d;
	logic [YW-1:0]  row_d;
	logic [2:0]     slot_d;
	logic [AW-1:0]  addr_top;
	logic [AW-1:0]  addr_mid;
	logic [7:0]     rd_top;
	logic [7:0]     rd_mid;

	// Stage one: the line store read is in flight.
	logic             v_s1;
	logic [7:0]       px_s1;
	logic             emit_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic             done_s1;

	// Stage two: the window holds the footprint of this item.
	logic             v_s2;
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;
	logic             done_s2;

	logic [7:0] win_q [3][7];
	grad_t      gx;
	grad_t      gy;

	function automatic grad_t sx(input logic [7:0] a);
		return grad_t'({3'b000, a});
	endfunction

	// Accept only while the queue has room for every item still in flight.
	assign pix_ready = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(v_s1) + (QCNT_W + 1)'(v_s2))
		< (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept = pix_valid & pix_ready;

	// Current position; a frame start restarts at the top-left corner.
	always_comb begin
		x        = pix.frame_start ? '0 : col_q;
		y        = pix.frame_start ? '0 : row_q;
		slot     = pix.frame_start ? '0 : slot_q;
		slot_mid = (slot >= 3'd3) ? slot - 3'd3 : slot + 3'd3;
		w_use    = (WCW'(frame_width) > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : WCW'(frame_width);
		h_use    = (HCW'(frame_height) > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : HCW'(frame_height);
		x_inc    = WCW'(x) + WCW'(1);
		y_inc    = HCW'(y) + HCW'(1);
		emit     = (y >= YW'(6)) && (x >= XW'(6)) && (y_inc < h_use) && (x_inc < w_use);
		last     = ((y_inc + HCW'(1)) == h_use) && ((x_inc + WCW'(1)) == w_use);
		x_m6     = x - XW'(6);
		y_m6     = y - YW'(6);
	end

	// Raster advance with wrap at the end of a line and of a frame.
	always_comb begin
		col_d  = XW'(x_inc);
		row_d  = y;
		slot_d = slot;
		if (x_inc >= w_use) begin
			col_d = '0;
			if (y_inc >= h_use) begin
				row_d  = '0;
				slot_d = '0;
			end else begin
				row_d  = YW'(y_inc);
				slot_d = (slot == 3'd5) ? 3'd0 : slot + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			col_q  <= col_d;
			row_q  <= row_d;
			slot_q <= slot_d;
		end
	end

	// Line stores: read rows y-6 and y-3 of this column, then overwrite the oldest.
	assign addr_top = AW'(slot) * AW'(MAX_WIDTH) + AW'(x);
	assign addr_mid = AW'(slot_mid) * AW'(MAX_WIDTH) + AW'(x);

	dset_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_line_store (
		.clk      (clk),
		.wr_en    (accept),
		.wr_addr  (addr_top),
		.wr_data  (pix.pixel),
		.rd_en    (accept),
		.rd_addr_a(addr_top),
		.rd_addr_b(addr_mid),
		.rd_data_a(rd_top),
		.rd_data_b(rd_mid)
	);

	// Stage one registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pix.pixel;
			emit_s1 <= emit;
			row_s1  <= ROW_W'(y_m6);
			col_s1  <= COL_W'(x_m6);
			done_s1 <= last;
		end
	end

	// Window shift: one column enters per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 7; i++) begin
					win_q[k][i] <= '0;
				end
			end
		end else if (v_s1) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 6; i++) begin
					win_q[k][i] <= win_q[k][i+1];
				end
			end
			win_q[0][6] <= rd_top;
			win_q[1][6] <= rd_mid;
			win_q[2][6] <= px_s1;
		end
	end

	// Stage two registers; only items that yield a result are marked valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 & emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			done_s2 <= done_s1;
		end
	end

	// Dilated Sobel taps over the 7x7 footprint.
	always_comb begin
		gx = sx(win_q[0][6]) - sx(win_q[0][0])
			+ ((sx(win_q[1][6]) - sx(win_q[1][0])) <<< 1)
			+ sx(win_q[2][6]) - sx(win_q[2][0]);
		gy = sx(win_q[2][0]) - sx(win_q[0][0])
			+ ((sx(win_q[2][3]) - sx(win_q[0][3])) <<< 1)
			+ sx(win_q[2][6]) - sx(win_q[0][6]);
	end

	assign push           = v_s2;
	assign push_item.gx   = gx;
	assign push_item.gy   = gy;
	assign push_item.row  = row_s2;
	assign push_item.col  = col_s2;
	assign push_item.done = done_s2;

endmodule

// ===== hw/rtl/dset_queue.sv =====
// Short register queue between the front and the back part.
module dset_queue import dset_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  grad_item_t        push_item,
	input  logic              pop,
	output grad_item_t        pop_item,
	output logic              empty,
	output logic [QCNT_W-1:0] count
);

	grad_item_t        entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Pointer and fill level bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	assign pop_item = entry_q[rd_ptr_q];
	assign empty    = (count_q == '0);
	assign count    = count_q;

endmodule

// ===== hw/rtl/dset_back.sv =====
// Back part: squared gradient magnitude, threshold compare and result register.
module dset_back import dset_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  grad_item_t          q_item,
	output logic                q_pop,
	input  logic [THR_SQ_W-1:0] thr_sq,
	output res_t                res,
	output logic                res_valid,
	input  logic                res_ready
);

	logic en;

	logic signed [2*GRAD_W-1:0] prod_x;
	logic signed [2*GRAD_W-1:0] prod_y;

	// Stage one: the two squares.
	logic             v_s1;
	logic [SQ_W-1:0]  gx_sq_s1;
	logic [SQ_W-1:0]  gy_sq_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic             done_s1;

	logic [THR_SQ_W-1:0] mag;

	res_t res_q;
	logic res_valid_q;

	// The whole back part moves whenever the result register can take a new one.
	assign en    = ~res_valid_q | res_ready;
	assign q_pop = en & ~q_empty;

	assign prod_x = q_item.gx * q_item.gx;
	assign prod_y = q_item.gy * q_item.gy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			gx_sq_s1 <= SQ_W'(prod_x);
			gy_sq_s1 <= SQ_W'(prod_y);
			row_s1   <= q_item.row;
			col_s1   <= q_item.col;
			done_s1  <= q_item.done;
		end
	end

	// Full-width compare against the squared threshold.
	assign mag = THR_SQ_W'(gx_sq_s1) + THR_SQ_W'(gy_sq_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			res_q.edge_res   <= (mag > thr_sq) ? EDGE_ON : EDGE_OFF;
			res_q.out_row    <= row_s1;
			res_q.out_col    <= col_s1;
			res_q.frame_done <= done_s1;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

// ===== hw/rtl/dilated_sobel_edge_threshold_unit.sv =====
// Top level of the dilated Sobel edge threshold unit: configuration registers and wiring.
// The unit takes one grayscale pixel per clock in raster order and keeps taking
// one per clock as long as results are taken at the same pace. A result passes
// through five registers in order, the first loaded at the edge that accepts the
// pixel completing its 7x7 footprint: the registered read of the six line stores,
// the window, the queue entry, the squaring stage and the output register.
// While the output is held, up to six results wait inside (four in the queue, one in
// the squaring stage and one in the output register); the pixel input stalls once the
// queue entries plus the pixels in the two front stages reach four. The line stores
// need no clearing after reset, since a frame only reads lines it has written.
// Configuration writes are taken at any time but must only be issued while no pixel
// is in flight; frame width and height above the built-in maxima are clipped to them.
module dilated_sobel_edge_threshold_unit import dset_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pix_t              pix,
	input  logic              pix_valid,
	output logic              pix_ready,
	output res_t              res,
	output logic              res_valid,
	input  logic              res_ready,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	logic [THR_SQ_W-1:0] thr_sq_q;
	logic [FW_W-1:0]     frame_width_q;
	logic [FH_W-1:0]     frame_height_q;
	logic [THR_W-1:0]    thr_in;
	logic [THR_SQ_W-1:0] thr_sq_in;

	logic              push;
	grad_item_t        push_item;
	logic              pop;
	grad_item_t        pop_item;
	logic              q_empty;
	logic [QCNT_W-1:0] q_count;

	// Configuration registers; the threshold is kept squared.
	assign cfg_ready = 1'b1;
	assign thr_in    = cfg_data[THR_W-1:0];
	assign thr_sq_in = THR_SQ_W'(thr_in) * THR_SQ_W'(thr_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q       <= THR_SQ_RESET;
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_THRESHOLD: begin
					thr_sq_q <= thr_sq_in;
				end
				CFG_WIDTH: begin
					frame_width_q <= cfg_data[FW_W-1:0];
				end
				CFG_HEIGHT: begin
					frame_height_q <= cfg_data[FH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	dset_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix         (pix),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.q_count     (q_count),
		.push        (push),
		.push_item   (push_item)
	);

	dset_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.pop_item (pop_item),
		.empty    (q_empty),
		.count    (q_count)
	);

	dset_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_item   (pop_item),
		.q_pop    (pop),
		.thr_sq   (thr_sq_q),
		.res      (res),
		.res_valid(res_valid),
		.res_ready(res_ready)
	);

endmodule
